### hw/rtl/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types, constants and helpers for the keyword substitution cipher.
// ----------------------------------------------------------------------------
package kwsc_pkg;

	localparam int KEY_CHARS   = 8;
	localparam int KEY_IDX_W   = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
	localparam int KEY_W       = 8 * KEY_CHARS;
	localparam int KEY_LEN_W   = 4;
	localparam int LETTERS     = 26;
	localparam int LETTER_W    = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	typedef logic [LETTER_W-1:0] letter_t;

	localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_CHARS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_LENGTH = 2'd1;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam letter_t    LAST_LETTER  = letter_t'(LETTERS - 1);

	typedef enum logic [1:0] {
		BLD_KEY,
		BLD_FILL,
		BLD_DONE
	} bld_state_t;

	typedef struct packed {
		logic    we;
		letter_t pos;
		letter_t letter;
	} tbl_wr_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
	endfunction

	function automatic letter_t letter_index(input logic [7:0] c);
		logic [7:0] d;
		d = is_upper(c) ? (c - CHAR_UPPER_A) : (c - CHAR_LOWER_A);
		return d[LETTER_W-1:0];
	endfunction

endpackage

### hw/rtl/kwsc_table_ram.sv
// ----------------------------------------------------------------------------
// kwsc_table_ram
// One-write, one-read letter table with a registered read port.
// ----------------------------------------------------------------------------
module kwsc_table_ram
	import kwsc_pkg::*;
(
	input  logic    clk,
	input  logic    we,
	input  letter_t waddr,
	input  letter_t wdata,
	input  logic    re,
	input  letter_t raddr,
	output letter_t rdata
);

	letter_t mem [LETTERS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/kwsc_builder.sv
// ----------------------------------------------------------------------------
// kwsc_builder
// Rebuilds the substitution alphabet and its inverse, at most one entry per cycle.
// ----------------------------------------------------------------------------
module kwsc_builder
	import kwsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [KEY_W-1:0]     keyword_chars,
	input  logic [KEY_LEN_W-1:0] keyword_length,
	output tbl_wr_t              wr,
	output logic                 busy
);

	bld_state_t          state_q, state_next;
	letter_t             pos_q;
	letter_t             count_q;
	logic [LETTERS-1:0]  placed_q;

	logic [KEY_IDX_W-1:0] key_idx;
	logic [7:0]           key_byte;
	logic [KEY_LEN_W-1:0] len_sat;
	logic                 key_letter;
	letter_t              key_code;
	logic                 key_last;
	logic                 fill_last;

	assign key_idx    = pos_q[KEY_IDX_W-1:0];
	assign key_byte   = keyword_chars[8*key_idx +: 8];
	assign len_sat    = (keyword_length > KEY_LEN_W'(KEY_CHARS)) ?
	                    KEY_LEN_W'(KEY_CHARS) : keyword_length;
	assign key_code   = letter_index(key_byte);
	assign key_letter = (is_upper(key_byte) || is_lower(key_byte)) &&
	                    ({{(8-LETTER_W){1'b0}}, pos_q} < {{(8-KEY_LEN_W){1'b0}}, len_sat});
	assign key_last   = (pos_q == letter_t'(KEY_CHARS - 1));
	assign fill_last  = (pos_q == LAST_LETTER);

	always_comb begin
		state_next = state_q;
		case (state_q)
			BLD_KEY:  if (key_last) state_next = BLD_FILL;
			BLD_FILL: if (fill_last) state_next = BLD_DONE;
			BLD_DONE: state_next = BLD_DONE;
			default:  state_next = BLD_DONE;
		endcase
		if (restart) begin
			state_next = BLD_KEY;
		end
	end

	always_comb begin
		wr   = '0;
		busy = 1'b1;
		case (state_q)
			BLD_KEY: begin
				wr.we     = key_letter && !placed_q[key_code];
				wr.pos    = count_q;
				wr.letter = key_code;
			end
			BLD_FILL: begin
				wr.we     = !placed_q[pos_q];
				wr.pos    = count_q;
				wr.letter = pos_q;
			end
			BLD_DONE: busy = 1'b0;
			default:  busy = 1'b0;
		endcase
		if (restart) begin
			wr.we = 1'b0;
			busy  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BLD_KEY;
			pos_q    <= '0;
			count_q  <= '0;
			placed_q <= '0;
		end else begin
			state_q <= state_next;
			if (restart) begin
				pos_q    <= '0;
				count_q  <= '0;
				placed_q <= '0;
			end else begin
				if (wr.we) begin
					count_q <= count_q + letter_t'(1);
				end
				if (state_q == BLD_KEY) begin
					if (wr.we) begin
						placed_q[key_code] <= 1'b1;
					end
					pos_q <= key_last ? '0 : pos_q + letter_t'(1);
				end else if (state_q == BLD_FILL) begin
					pos_q <= pos_q + letter_t'(1);
				end
			end
		end
	end

endmodule

### hw/rtl/kwsc_lookup.sv
// ----------------------------------------------------------------------------
// kwsc_lookup
// Item pipeline: table read stage, then the output register.
// ----------------------------------------------------------------------------
module kwsc_lookup
	import kwsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       bld_busy,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_tuser,
	input  logic [7:0] s_tdata,
	output logic       rd_en,
	output letter_t    rd_addr,
	input  letter_t    sub_rdata,
	input  letter_t    inv_rdata,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata
);

	logic       valid_s1;
	logic       op_s1;
	logic       letter_s1;
	logic       upper_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic       advance;
	letter_t    mapped;
	logic [7:0] base;
	logic [7:0] result;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !bld_busy && (!valid_s1 || advance);
	assign rd_en    = s_tvalid && s_tready;
	assign rd_addr  = letter_index(s_tdata);

	assign mapped = op_s1 ? inv_rdata : sub_rdata;
	assign base   = upper_s1 ? CHAR_UPPER_A : CHAR_LOWER_A;
	assign result = letter_s1 ? (base + {{(8-LETTER_W){1'b0}}, mapped}) : char_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			op_s1     <= s_tuser;
			letter_s1 <= is_upper(s_tdata) || is_lower(s_tdata);
			upper_s1  <= is_upper(s_tdata);
			char_s1   <= s_tdata;
		end
		if (advance && valid_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### hw/rtl/keyword_substitution_cipher_core.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_core
// Keyword substitution cipher: byte stream in, substituted byte stream out.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_*       in         tuser[0] = op (1 decrypts), tdata[7:0] = char_in
// m_*       out        tdata[7:0] = char_out
// cfg_*     in         index 0 keyword_chars, index 1 keyword_length
//
// One item per cycle while no table rebuild runs and the output is not stalled;
// each item passes through the read stage into the output register. After reset
// and after each write to index 0 or 1 the alphabet and its inverse are rewritten
// into the two table memories, at most one entry per cycle; s_tready stays low during that pass.
// A stalled output holds the read stage and then s_tready drops.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_core
	import kwsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_tuser,   // [0] op
	input  logic [7:0]            s_tdata,   // [7:0] char_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] char_out
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [KEY_W-1:0]     keyword_chars_q;
	logic [KEY_LEN_W-1:0] keyword_length_q;
	logic                 restart;
	tbl_wr_t              wr;
	logic                 bld_busy;
	logic                 rd_en;
	letter_t              rd_addr;
	letter_t              sub_rdata;
	letter_t              inv_rdata;

	assign restart = cfg_we &&
	                 ((cfg_index == REG_KEYWORD_CHARS) || (cfg_index == REG_KEYWORD_LENGTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_chars_q  <= '0;
			keyword_length_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEYWORD_CHARS) begin
				keyword_chars_q <= cfg_data[KEY_W-1:0];
			end else if (cfg_index == REG_KEYWORD_LENGTH) begin
				keyword_length_q <= cfg_data[KEY_LEN_W-1:0];
			end
		end
	end

	kwsc_builder u_builder (
		.clk            (clk),
		.arst_n         (arst_n),
		.restart        (restart),
		.keyword_chars  (keyword_chars_q),
		.keyword_length (keyword_length_q),
		.wr             (wr),
		.busy           (bld_busy)
	);

	kwsc_table_ram u_sub_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.pos),
		.wdata (wr.letter),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (sub_rdata)
	);

	kwsc_table_ram u_inv_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.letter),
		.wdata (wr.pos),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (inv_rdata)
	);

	kwsc_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.bld_busy  (bld_busy),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.sub_rdata (sub_rdata),
		.inv_rdata (inv_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### tb/kwsc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsc_stream_checker
// Watches the configuration port and both streams of the cipher core, keeps
// its own keyed alphabet and inverse, predicts each output byte and compares
// it with the byte that leaves the core, in order.
// ----------------------------------------------------------------------------
module kwsc_stream_checker
	import kwsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic                  s_tuser,
	input  logic [7:0]            s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [7:0]            m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending
);

	typedef logic [LETTERS-1:0][LETTER_W-1:0] alphabet_t;

	logic [KEY_W-1:0]     key_chars;
	logic [KEY_LEN_W-1:0] key_len;
	alphabet_t            fwd_alpha;
	alphabet_t            inv_alpha;
	logic [7:0]           pending_cipher_bytes[$];
	int                   fail_count;

	function automatic alphabet_t keyed_alphabet(input logic [KEY_W-1:0] chars,
	                                             input logic [KEY_LEN_W-1:0] len);
		alphabet_t       alpha;
		logic [LETTERS-1:0] used;
		logic [7:0]      b;
		logic [7:0]      d;
		logic            is_alpha;
		int              n;
		int              cnt;
		int              i;
		alpha = '0;
		used = '0;
		cnt = 0;
		n = (len > KEY_CHARS) ? KEY_CHARS : int'(len);
		for (i = 0; i < n; i++) begin
			b = chars[8*i +: 8];
			is_alpha = 1'b1;
			d = '0;
			if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
				d = b - CHAR_UPPER_A;
			end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
				d = b - CHAR_LOWER_A;
			end else begin
				is_alpha = 1'b0;
			end
			if (is_alpha && !used[d[LETTER_W-1:0]]) begin
				used[d[LETTER_W-1:0]] = 1'b1;
				alpha[cnt] = d[LETTER_W-1:0];
				cnt++;
			end
		end
		for (i = 0; i < LETTERS; i++) begin
			if (!used[i]) begin
				alpha[cnt] = i[LETTER_W-1:0];
				cnt++;
			end
		end
		return alpha;
	endfunction

	function automatic alphabet_t inverted(input alphabet_t alpha);
		alphabet_t inv;
		int        i;
		inv = '0;
		for (i = 0; i < LETTERS; i++) begin
			inv[alpha[i]] = i[LETTER_W-1:0];
		end
		return inv;
	endfunction

	function automatic logic [7:0] cipher_byte(input logic decrypt, input logic [7:0] c);
		logic [7:0]          base;
		logic [7:0]          d;
		logic [LETTER_W-1:0] mapped;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			base = CHAR_UPPER_A;
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			base = CHAR_LOWER_A;
		end else begin
			return c;
		end
		d = c - base;
		mapped = decrypt ? inv_alpha[d[LETTER_W-1:0]] : fwd_alpha[d[LETTER_W-1:0]];
		return base + {3'b000, mapped};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [KEY_W-1:0]     nxt_chars;
		logic [KEY_LEN_W-1:0] nxt_len;
		logic [7:0]           want;
		if (!arst_n) begin
			key_chars <= '0;
			key_len <= '0;
			fwd_alpha <= keyed_alphabet('0, '0);
			inv_alpha <= inverted(keyed_alphabet('0, '0));
			pending_cipher_bytes.delete();
			fail_count = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_cipher_bytes.size() == 0) begin
					$error("char_out: expected none, actual %h", m_tdata);
					fail_count++;
				end else begin
					want = pending_cipher_bytes.pop_front();
					if (m_tdata !== want) begin
						$error("char_out: expected %h, actual %h", want, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pending_cipher_bytes.push_back(cipher_byte(s_tuser, s_tdata));
			end
			if (cfg_we && (cfg_index == REG_KEYWORD_CHARS || cfg_index == REG_KEYWORD_LENGTH)) begin
				nxt_chars = key_chars;
				nxt_len = key_len;
				if (cfg_index == REG_KEYWORD_CHARS) begin
					nxt_chars = cfg_data[KEY_W-1:0];
				end else begin
					nxt_len = cfg_data[KEY_LEN_W-1:0];
				end
				key_chars <= nxt_chars;
				key_len <= nxt_len;
				fwd_alpha <= keyed_alphabet(nxt_chars, nxt_len);
				inv_alpha <= inverted(keyed_alphabet(nxt_chars, nxt_len));
			end
			fails <= fail_count;
			pending <= pending_cipher_bytes.size();
		end
	end

endmodule

### tb/tb_keyword_substitution_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher_core
// Drives the cipher core with directed and random byte streams under several
// keywords, with random idling on both streams and one long output stall,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher_core;
	import kwsc_pkg::*;

	localparam logic                 OP_ENCRYPT   = 1'b0;
	localparam logic                 OP_DECRYPT   = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;
	localparam int                   CYCLE_LIMIT  = 400000;
	localparam int                   RAND_PHASES  = 12;
	localparam int                   PHASE_ITEMS  = 70;
	localparam int                   HOLD_CYCLES  = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic                  s_tuser;   // [0] op
	logic [7:0]            s_tdata;   // [7:0] char_in
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;   // [7:0] char_out
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;
	int                    cycles;
	logic                  calm;
	logic                  hold_off;

	keyword_substitution_cipher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	kwsc_stream_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		cycles = 0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("keyword_substitution_cipher_core verification failed");
			$finish;
		end
	end

	task automatic wait_table_ready();
		repeat (2) @(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		wait_table_ready();
	endtask

	task automatic push_byte(input logic op, input logic [7:0] ch);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!calm && !hold_off && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic end_phase();
		s_tvalid <= 1'b0;
		wait_drained();
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] off;
		off = 8'($urandom_range(0, LETTERS - 1));
		return ($urandom_range(0, 1) == 0) ? CHAR_UPPER_A + off : CHAR_LOWER_A + off;
	endfunction

	function automatic logic [KEY_W-1:0] random_keyword();
		logic [KEY_W-1:0] k;
		int               i;
		for (i = 0; i < KEY_CHARS; i++) begin
			k[8*i +: 8] = ($urandom_range(0, 3) != 0) ? random_letter() : 8'($urandom);
		end
		return k;
	endfunction

	always begin
		@(posedge clk);
		if (hold_off) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off = 1'b0;
			m_tready <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] val;
		int                    p;
		int                    n;
		int                    mode;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_table_ready();

		// Plain alphabet, letter boundaries and their neighbors.
		push_byte(OP_ENCRYPT, CHAR_UPPER_A);
		push_byte(OP_DECRYPT, CHAR_UPPER_Z);
		push_byte(OP_ENCRYPT, CHAR_LOWER_A);
		push_byte(OP_DECRYPT, CHAR_LOWER_Z);
		push_byte(OP_ENCRYPT, 8'h00);
		push_byte(OP_DECRYPT, 8'hFF);
		push_byte(OP_ENCRYPT, CHAR_UPPER_A - 8'd1);
		push_byte(OP_DECRYPT, CHAR_UPPER_Z + 8'd1);
		push_byte(OP_ENCRYPT, CHAR_LOWER_A - 8'd1);
		push_byte(OP_DECRYPT, CHAR_LOWER_Z + 8'd1);
		end_phase();

		// Repeated letters in both cases, a digit, a high byte, and an
		// oversized length that saturates. Writes to spare indexes are ignored.
		write_reg(REG_KEYWORD_CHARS, {8'h85, "A", "r", "Z", "9", "b", "E", "z"});
		write_reg(REG_KEYWORD_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE_2, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE_3, 64'({$urandom, $urandom}));
		push_byte(OP_ENCRYPT, "a");
		push_byte(OP_DECRYPT, "B");
		push_byte(OP_ENCRYPT, "Y");
		push_byte(OP_DECRYPT, "m");
		push_byte(OP_ENCRYPT, "Q");
		push_byte(OP_DECRYPT, "z");
		end_phase();

		// A keyword of non-letters only, then an empty keyword.
		write_reg(REG_KEYWORD_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
		push_byte(OP_ENCRYPT, "D");
		end_phase();
		write_reg(REG_KEYWORD_LENGTH, 64'd0);
		push_byte(OP_DECRYPT, "d");
		end_phase();

		for (p = 0; p < RAND_PHASES; p++) begin
			mode = $urandom_range(0, 5);
			if (p == 0) begin
				val = {"H", "G", "F", "E", "D", "C", "B", "X"};
			end else if (mode == 0) begin
				val = '0;
			end else if (mode == 1) begin
				val = 64'({$urandom, $urandom});
			end else begin
				val = random_keyword();
			end
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_KEYWORD_CHARS, val);
			end
			if (p == 1) begin
				write_reg(REG_KEYWORD_LENGTH, 64'd8);
			end else begin
				write_reg(REG_KEYWORD_LENGTH,
				          {60'({$urandom, $urandom}), 4'($urandom_range(0, 15))});
			end
			write_reg(REG_KEYWORD_CHARS, val);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
				          64'({$urandom, $urandom}));
			end
			if (p == 4) begin
				hold_off = 1'b1;
			end
			if (p == RAND_PHASES - 1) begin
				calm = 1'b1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				push_byte(($urandom_range(0, 1) == 0) ? OP_ENCRYPT : OP_DECRYPT,
				          ($urandom_range(0, 9) < 7) ? random_letter() : 8'($urandom));
			end
			end_phase();
		end

		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("keyword_substitution_cipher_core verification clean");
		end else begin
			$display("keyword_substitution_cipher_core verification failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/kwsc_pkg.sv
hw/rtl/kwsc_table_ram.sv
hw/rtl/kwsc_builder.sv
hw/rtl/kwsc_lookup.sv
hw/rtl/keyword_substitution_cipher_core.sv
tb/kwsc_stream_checker.sv
tb/tb_keyword_substitution_cipher_core.sv
